### hdl/rlle_pkg.sv
package rlle_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] REPEAT_BIAS  = 8'd127;
  localparam logic [BYTE_W-1:0] LITERAL_BIAS = 8'd1;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic {
    KIND_LITERAL,
    KIND_REPEAT
  } rlle_kind_e;

  // One closed run handed from the front end to the back end.
  typedef struct packed {
    rlle_kind_e        kind;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] value;
    logic              bank;
  } rlle_cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rlle_release_t;

endpackage

### hdl/rlle_ram.sv
module rlle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 126
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rlle_queue.sv
module rlle_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rlle_pkg::rlle_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output rlle_pkg::rlle_cmd_t head_o
);
  import rlle_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  rlle_cmd_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [FW-1:0]   fill_q, fill_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  assign full_o  = (fill_q == FW'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rptr_q];

endmodule

### hdl/rlle_front.sv
module rlle_front #(
  parameter int unsigned RUN_LIMIT = 63,
  parameter int unsigned AW        = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    cmd_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output rlle_pkg::rlle_cmd_t     push_cmd_o,
  output logic                    we_o,
  output logic [AW-1:0]           waddr_o,
  output logic [7:0]              wdata_o,
  input  rlle_pkg::rlle_release_t release_i
);
  import rlle_pkg::*;

  localparam int unsigned CW = $clog2(RUN_LIMIT + 2);
  localparam int unsigned IW = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;
  localparam logic [AW-1:0] BANK_OFS = AW'(RUN_LIMIT);

  logic [CW-1:0]     count_q, count_d;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic              rep_q, rep_d;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;
  logic              accept;
  logic [CW-1:0]     cnt_inc;
  logic [IW-1:0]     widx;

  assign in_stall_o = q_full_i || busy_q[bank_q];
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_inc    = count_q + 1'b1;

  always_comb begin
    count_d    = count_q;
    prev_d     = prev_q;
    rep_d      = rep_q;
    bank_d     = bank_q;
    push_o     = 1'b0;
    push_cmd_o = '0;
    we_o       = 1'b0;
    widx       = '0;
    if (accept) begin
      if (cmd_i == CMD_END) begin
        if (count_q != '0) begin
          push_o           = 1'b1;
          push_cmd_o.count = CNT_W'(count_q);
          push_cmd_o.value = prev_q;
          push_cmd_o.bank  = bank_q;
          if (rep_q) begin
            push_cmd_o.kind = KIND_REPEAT;
          end else begin
            push_cmd_o.kind = KIND_LITERAL;
            bank_d          = !bank_q;
          end
        end
        count_d = '0;
        prev_d  = '0;
        rep_d   = 1'b0;
      end else if (count_q == '0) begin
        we_o    = 1'b1;
        count_d = CW'(1);
        prev_d  = data_byte_i;
        rep_d   = 1'b0;
      end else if (rep_q) begin
        if (data_byte_i == prev_q) begin
          if (cnt_inc >= CW'(RUN_LIMIT)) begin
            push_o           = 1'b1;
            push_cmd_o.kind  = KIND_REPEAT;
            push_cmd_o.count = CNT_W'(cnt_inc);
            push_cmd_o.value = data_byte_i;
            push_cmd_o.bank  = bank_q;
            count_d          = '0;
            rep_d            = 1'b0;
          end else begin
            count_d = cnt_inc;
          end
        end else begin
          push_o           = 1'b1;
          push_cmd_o.kind  = KIND_REPEAT;
          push_cmd_o.count = CNT_W'(count_q);
          push_cmd_o.value = prev_q;
          push_cmd_o.bank  = bank_q;
          we_o             = 1'b1;
          count_d          = CW'(1);
          prev_d           = data_byte_i;
          rep_d            = 1'b0;
        end
      end else begin
        if (data_byte_i == prev_q) begin
          // The last literal byte joins the new repeat run.
          if (count_q != CW'(1)) begin
            push_o           = 1'b1;
            push_cmd_o.kind  = KIND_LITERAL;
            push_cmd_o.count = CNT_W'(count_q - 1'b1);
            push_cmd_o.value = prev_q;
            push_cmd_o.bank  = bank_q;
            bank_d           = !bank_q;
          end
          count_d = CW'(2);
          rep_d   = 1'b1;
        end else begin
          we_o    = 1'b1;
          widx    = count_q[IW-1:0];
          prev_d  = data_byte_i;
          if (cnt_inc >= CW'(RUN_LIMIT)) begin
            push_o           = 1'b1;
            push_cmd_o.kind  = KIND_LITERAL;
            push_cmd_o.count = CNT_W'(cnt_inc);
            push_cmd_o.value = data_byte_i;
            push_cmd_o.bank  = bank_q;
            bank_d           = !bank_q;
            count_d          = '0;
          end else begin
            count_d = cnt_inc;
          end
        end
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (push_o && (push_cmd_o.kind == KIND_LITERAL)) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  assign waddr_o = AW'(widx) + (bank_q ? BANK_OFS : '0);
  assign wdata_o = data_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      prev_q  <= '0;
      rep_q   <= 1'b0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      count_q <= count_d;
      prev_q  <= prev_d;
      rep_q   <= rep_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

### hdl/rlle_back.sv
module rlle_back #(
  parameter int unsigned RUN_LIMIT = 63,
  parameter int unsigned AW        = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  rlle_pkg::rlle_cmd_t     head_i,
  output logic                    pop_o,
  output logic                    re_o,
  output logic [AW-1:0]           raddr_o,
  input  logic [7:0]              rdata_i,
  output rlle_pkg::rlle_release_t release_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    is_header_o,
  output logic                    last_o
);
  import rlle_pkg::*;

  localparam int unsigned IW = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;
  localparam logic [AW-1:0] BANK_OFS = AW'(RUN_LIMIT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_REP  = 2'd2;

  logic [1:0]        state_q, state_d;
  rlle_cmd_t         cmd_q, cmd_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              hdr_q, hdr_d;
  logic              last_q, last_d;
  logic              load_ok;
  logic              lit_done;
  logic              rbank;
  logic [IW-1:0]     ridx;

  assign load_ok  = !valid_q || !out_stall_i;
  assign lit_done = ((CNT_W'(idx_q) + 1'b1) == cmd_q.count);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    valid_d   = valid_q;
    byte_d    = byte_q;
    hdr_d     = hdr_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    re_o      = 1'b0;
    ridx      = '0;
    rbank     = cmd_q.bank;
    release_o = '0;
    if (load_ok) begin
      valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        rbank = head_i.bank;
        if (load_ok && !q_empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = head_i;
          valid_d = 1'b1;
          hdr_d   = 1'b1;
          last_d  = 1'b0;
          if (head_i.kind == KIND_LITERAL) begin
            byte_d  = head_i.count - LITERAL_BIAS;
            re_o    = 1'b1;
            idx_d   = '0;
            state_d = S_LIT;
          end else begin
            byte_d  = head_i.count + REPEAT_BIAS;
            state_d = S_REP;
          end
        end
      end
      S_REP: begin
        if (load_ok) begin
          valid_d = 1'b1;
          byte_d  = cmd_q.value;
          hdr_d   = 1'b0;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LIT: begin
        if (load_ok) begin
          valid_d = 1'b1;
          byte_d  = rdata_i;
          hdr_d   = 1'b0;
          last_d  = lit_done;
          if (lit_done) begin
            release_o.valid = 1'b1;
            release_o.bank  = cmd_q.bank;
            state_d         = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            re_o  = 1'b1;
            ridx  = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign raddr_o = AW'(ridx) + (rbank ? BANK_OFS : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    byte_q <= byte_d;
    hdr_q  <= hdr_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign is_header_o = hdr_q;
  assign last_o      = last_q;

endmodule

### hdl/run_length_literal_encoder_unit.sv
// Run-length encoder for records of bytes; headers n-1 literal, n+127 repeat.
// The input channel takes one word per item: cmd_i low carries a data byte in
// data_byte_i, cmd_i high marks the end of a record and closes the open run.
// The output channel gives one word per result: a run header or a payload
// byte, with last_o set on the final word caused by an input item.
// A literal run of n bytes gives n+1 words, a repeat run gives two.
// The front end takes one input word per cycle unless stalled and hands each
// closed run to a two-entry command queue; literal bytes sit in a two-bank
// store so that the next run can fill one bank while the back end reads the
// other. The back end sends one word per cycle unless the output stalls,
// with no gap between runs while the queue holds one. A closed run is written
// into the queue, and its first word is then registered into the output word
// when the back end is free. The input stalls while the queue is full or the
// bank it must fill holds a literal run not fully read. A stalled output word
// is held; the back end waits and the front end runs on until the queue fills
// or its bank is busy. Reset clears front end run state, back end state, queue
// pointers and output valid; the byte store is not cleared and needs none.
module run_length_literal_encoder_unit #(
  parameter int unsigned RUN_LIMIT = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_header_o,
  output logic       last_o
);
  import rlle_pkg::*;

  localparam int unsigned DEPTH = 2 * RUN_LIMIT;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic            q_full;
  logic            q_empty;
  logic            push;
  rlle_cmd_t       push_cmd;
  logic            pop;
  rlle_cmd_t       head;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  rlle_release_t   release_s;

  rlle_front #(
    .RUN_LIMIT(RUN_LIMIT),
    .AW       (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .data_byte_i(data_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .we_o       (ram_we),
    .waddr_o    (ram_waddr),
    .wdata_o    (ram_wdata),
    .release_i  (release_s)
  );

  rlle_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .head_o    (head)
  );

  rlle_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rlle_back #(
    .RUN_LIMIT(RUN_LIMIT),
    .AW       (AW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .head_i     (head),
    .pop_o      (pop),
    .re_o       (ram_re),
    .raddr_o    (ram_raddr),
    .rdata_i    (ram_rdata),
    .release_o  (release_s),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .is_header_o(is_header_o),
    .last_o     (last_o)
  );

  a_header_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_header_o |-> !last_o)
    else $error("run header marked as last word");

  a_payload_follows_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && is_header_o |=> out_valid_o && !is_header_o)
    else $error("header not followed by its payload");

  a_store_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("store written at the entry being read");

endmodule
